// ===== rtl/jsu_pkg.sv =====
// Shared types and constants of the JSON string unescaper.
package jsu_pkg;

	// Result status codes.
	localparam logic [2:0] StData   = 3'd0;
	localparam logic [2:0] StDone   = 3'd1;
	localparam logic [2:0] StMissQ  = 3'd2;
	localparam logic [2:0] StBadHex = 3'd3;
	localparam logic [2:0] StBadSur = 3'd4;
	localparam logic [2:0] StBadEsc = 3'd5;
	localparam logic [2:0] StCtrl   = 3'd6;

	// Depth of the queue between the decoder and the byte emitter.
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// One queued job: a code point to emit as len_m1+1 UTF-8 bytes, or a
	// single status result. A raw byte is a code point with len_m1 of zero.
	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  len_m1;
		logic [20:0] cp;
	} jsu_entry_t;

endpackage

// ===== rtl/jsu_front.sv =====
// Decoder front: accepts source bytes, runs the escape state machine and queues jobs.
module jsu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] in_byte
	input  logic               s_axis_tuser,   // [0] start_req
	input  logic               q_full,
	output logic               q_push,
	output jsu_pkg::jsu_entry_t q_entry
);

	localparam logic [2:0] PhIdle   = 3'd0;
	localparam logic [2:0] PhBody   = 3'd1;
	localparam logic [2:0] PhEsc    = 3'd2;
	localparam logic [2:0] PhHex1   = 3'd3;
	localparam logic [2:0] PhWantBs = 3'd4;
	localparam logic [2:0] PhWantU  = 3'd5;
	localparam logic [2:0] PhHex2   = 3'd6;
	localparam logic [2:0] PhHalt   = 3'd7;

	logic [2:0]  phase_q, phase_d, ph;
	logic [15:0] hex_accum_q, hex_accum_d, new_acc;
	logic [9:0]  high_sur_q, high_sur_d;
	logic [1:0]  digit_cnt_q, digit_cnt_d;
	logic [7:0]  c;
	logic [3:0]  dval;
	logic        hex_ok, four_done, accept, push_c;
	logic [20:0] pair_cp;
	jsu_pkg::jsu_entry_t entry_c;

	function automatic logic [1:0] len_of(input logic [20:0] cp);
		if (cp <= 21'h00007F)      len_of = 2'd0;
		else if (cp <= 21'h0007FF) len_of = 2'd1;
		else if (cp <= 21'h00FFFF) len_of = 2'd2;
		else                       len_of = 2'd3;
	endfunction

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign c             = s_axis_tdata;

	always_comb begin
		hex_ok = 1'b1;
		dval   = c[3:0];
		if (c inside {[8'h30:8'h39]}) begin
			dval = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			dval = c[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		ph          = s_axis_tuser ? PhBody : phase_q;
		phase_d     = ph;
		hex_accum_d = s_axis_tuser ? 16'd0 : hex_accum_q;
		digit_cnt_d = s_axis_tuser ? 2'd0 : digit_cnt_q;
		high_sur_d  = s_axis_tuser ? 10'd0 : high_sur_q;
		new_acc     = {hex_accum_d[11:0], dval};
		four_done   = (digit_cnt_d == 2'd3);
		pair_cp     = {1'b0, high_sur_d, new_acc[9:0]} + 21'h010000;
		push_c      = 1'b0;
		entry_c     = '0;
		case (ph)
			PhBody: begin
				push_c = 1'b1;
				if (c == 8'h22) begin
					entry_c.status = jsu_pkg::StDone;
					phase_d        = PhHalt;
				end else if (c == 8'h00) begin
					entry_c.status = jsu_pkg::StMissQ;
					phase_d        = PhHalt;
				end else if (c == 8'h5C) begin
					push_c  = 1'b0;
					phase_d = PhEsc;
				end else if (c < 8'h20) begin
					entry_c.status = jsu_pkg::StCtrl;
					phase_d        = PhHalt;
				end else begin
					entry_c.cp = {13'd0, c};
				end
			end
			PhEsc: begin
				push_c  = 1'b1;
				phase_d = PhBody;
				case (c)
					8'h22, 8'h5C, 8'h2F: entry_c.cp = {13'd0, c};
					8'h62:   entry_c.cp = 21'h08;
					8'h66:   entry_c.cp = 21'h0C;
					8'h6E:   entry_c.cp = 21'h0A;
					8'h72:   entry_c.cp = 21'h0D;
					8'h74:   entry_c.cp = 21'h09;
					8'h75: begin
						push_c      = 1'b0;
						phase_d     = PhHex1;
						hex_accum_d = 16'd0;
						digit_cnt_d = 2'd0;
					end
					default: begin
						entry_c.status = jsu_pkg::StBadEsc;
						phase_d        = PhHalt;
					end
				endcase
			end
			PhHex1, PhHex2: begin
				if (!hex_ok) begin
					push_c         = 1'b1;
					entry_c.status = jsu_pkg::StBadHex;
					phase_d        = PhHalt;
				end else begin
					hex_accum_d = new_acc;
					digit_cnt_d = digit_cnt_d + 2'd1;
					if (four_done) begin
						push_c = 1'b1;
						if (ph == PhHex1) begin
							if (new_acc >= 16'hD800 && new_acc <= 16'hDBFF) begin
								push_c     = 1'b0;
								high_sur_d = new_acc[9:0];
								phase_d    = PhWantBs;
							end else begin
								entry_c.cp     = {5'd0, new_acc};
								entry_c.len_m1 = len_of({5'd0, new_acc});
								phase_d        = PhBody;
							end
						end else if (new_acc < 16'hDC00 || new_acc > 16'hDFFF) begin
							entry_c.status = jsu_pkg::StBadSur;
							phase_d        = PhHalt;
						end else begin
							// A valid pair always lands in the four-byte range.
							entry_c.cp     = pair_cp;
							entry_c.len_m1 = 2'd3;
							phase_d        = PhBody;
						end
					end
				end
			end
			PhWantBs, PhWantU: begin
				if (c != ((ph == PhWantBs) ? 8'h5C : 8'h75)) begin
					push_c         = 1'b1;
					entry_c.status = jsu_pkg::StBadSur;
					phase_d        = PhHalt;
				end else if (ph == PhWantBs) begin
					phase_d = PhWantU;
				end else begin
					phase_d     = PhHex2;
					hex_accum_d = 16'd0;
					digit_cnt_d = 2'd0;
				end
			end
			default: begin
				phase_d = ph;
			end
		endcase
	end

	assign q_push  = accept && push_c;
	assign q_entry = entry_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PhIdle;
			hex_accum_q <= '0;
			high_sur_q  <= '0;
			digit_cnt_q <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			hex_accum_q <= hex_accum_d;
			high_sur_q  <= high_sur_d;
			digit_cnt_q <= digit_cnt_d;
		end
	end

endmodule

// ===== rtl/jsu_fifo.sv =====
// Small register queue of decoded jobs between the front and the emitter.
module jsu_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jsu_pkg::jsu_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output jsu_pkg::jsu_entry_t head
);

	jsu_pkg::jsu_entry_t           mem_q [jsu_pkg::QDepth];
	logic [jsu_pkg::QPtrW-1:0]     wr_q, rd_q;
	logic [jsu_pkg::QCntW-1:0]     cnt_q;
	logic                          do_push, do_pop;

	function automatic logic [jsu_pkg::QPtrW-1:0] nxt(input logic [jsu_pkg::QPtrW-1:0] p);
		if (p == jsu_pkg::QPtrW'(jsu_pkg::QDepth - 1)) nxt = '0;
		else                                           nxt = p + jsu_pkg::QPtrW'(1);
	endfunction

	assign full    = (cnt_q == jsu_pkg::QCntW'(jsu_pkg::QDepth));
	assign empty   = (cnt_q == '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= nxt(wr_q);
			if (do_pop)  rd_q <= nxt(rd_q);
			if (do_push && !do_pop)      cnt_q <= cnt_q + jsu_pkg::QCntW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - jsu_pkg::QCntW'(1);
		end
	end

endmodule

// ===== rtl/jsu_back.sv =====
// Emitter back end: expands queued jobs into UTF-8 bytes behind an output register.
module jsu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  jsu_pkg::jsu_entry_t q_head,
	output logic                q_pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,  // [7:0] out_byte
	output logic [2:0]          m_axis_tuser,  // [2:0] status
	output logic                m_axis_tlast
);

	logic [1:0]  idx_q;
	logic        valid_q, last_q;
	logic [7:0]  byte_q, byte_c;
	logic [2:0]  status_q;
	logic        load, is_last;
	logic [20:0] cp;

	assign cp      = q_head.cp;
	assign load    = !q_empty && (!valid_q || m_axis_tready);
	assign is_last = (idx_q == q_head.len_m1);
	assign q_pop   = load && is_last;

	// Lead byte first, then six-bit continuation groups from the top down.
	always_comb begin
		byte_c = cp[7:0];
		case (q_head.len_m1)
			2'd1: begin
				case (idx_q)
					2'd0:    byte_c = {3'b110, cp[10:6]};
					default: byte_c = {2'b10, cp[5:0]};
				endcase
			end
			2'd2: begin
				case (idx_q)
					2'd0:    byte_c = {4'b1110, cp[15:12]};
					2'd1:    byte_c = {2'b10, cp[11:6]};
					default: byte_c = {2'b10, cp[5:0]};
				endcase
			end
			2'd3: begin
				case (idx_q)
					2'd0:    byte_c = {5'b11110, cp[20:18]};
					2'd1:    byte_c = {2'b10, cp[17:12]};
					2'd2:    byte_c = {2'b10, cp[11:6]};
					default: byte_c = {2'b10, cp[5:0]};
				endcase
			end
			default: byte_c = cp[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (m_axis_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= byte_c;
			status_q <= q_head.status;
			last_q   <= is_last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = byte_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tlast  = last_q;

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
// The first result of a source byte passes through the job queue and then the output register.
// Throughput: one source byte per cycle in, stalling only when the job queue is full; one
// result byte per cycle out while m_axis_tready is high, so a \u escape or surrogate pair
// yielding up to four bytes holds the emitter while the four-entry queue keeps input moving.
// Reset (arst_n low) clears the decoder to idle and empties the queue and output register.
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tuser,   // [0] start_req
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [2:0] m_axis_tuser,   // [2:0] status
	output logic       m_axis_tlast
);

	logic                q_push, q_full, q_pop, q_empty;
	jsu_pkg::jsu_entry_t q_in, q_head;

	jsu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (q_in)
	);

	jsu_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	jsu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
